/* sv/blbw_pkg.sv */
package blbw_pkg;

    localparam int QUO_W = 8;

    typedef enum logic [2:0] {
        SECT_0 = 3'd0,
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5
    } t_sector;

    localparam logic [7:0]  BRIGHT_RESET = 8'd255;
    localparam logic [16:0] RECIP_LOW    = 17'd65794;
    localparam logic [24:0] RECIP_MID    = 25'd16909061;

endpackage

/* sv/blbw_if.sv */
interface blbw_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       last_pixel;
    modport source (output valid, red_in, green_in, blue_in, last_pixel, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, last_pixel, output ready);
endinterface

interface blbw_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] led_word;
    logic        last_word;
    modport source (output valid, led_word, last_word, input ready);
    modport sink   (input valid, led_word, last_word, output ready);
endinterface

interface blbw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] brightness;
    modport source (output valid, brightness, input ready);
    modport sink   (input valid, brightness, output ready);
endinterface

/* sv/blbw_div2.sv */
module blbw_div2 #(
    parameter int DVD_W  = 19,
    parameter int DVS_W  = 11,
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [DVD_W-1:0]              i_dvd_a,
    input  logic [DVS_W-1:0]              i_dvs_a,
    input  logic [DVD_W-1:0]              i_dvd_b,
    input  logic [DVS_W-1:0]              i_dvs_b,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [blbw_pkg::QUO_W-1:0]    o_quo_a,
    output logic [blbw_pkg::QUO_W-1:0]    o_quo_b,
    output logic [SIDE_W-1:0]             o_side
);
    import blbw_pkg::*;

    localparam int EXT_W = DVD_W + QUO_W;

    logic                w_vld   [QUO_W+1];
    logic [DVD_W-1:0]    w_rem_a [QUO_W+1];
    logic [DVD_W-1:0]    w_rem_b [QUO_W+1];
    logic [DVS_W-1:0]    w_dvs_a [QUO_W+1];
    logic [DVS_W-1:0]    w_dvs_b [QUO_W+1];
    logic [QUO_W-1:0]    w_quo_a [QUO_W+1];
    logic [QUO_W-1:0]    w_quo_b [QUO_W+1];
    logic [SIDE_W-1:0]   w_side  [QUO_W+1];

    assign w_vld[0]   = i_valid;
    assign w_rem_a[0] = i_dvd_a;
    assign w_rem_b[0] = i_dvd_b;
    assign w_dvs_a[0] = i_dvs_a;
    assign w_dvs_b[0] = i_dvs_b;
    assign w_quo_a[0] = '0;
    assign w_quo_b[0] = '0;
    assign w_side[0]  = i_side;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [EXT_W-1:0]  sh_a, sh_b;
        logic              ge_a, ge_b;
        logic              r_vld;
        logic [DVD_W-1:0]  r_rem_a, r_rem_b;
        logic [DVS_W-1:0]  r_dvs_a, r_dvs_b;
        logic [QUO_W-1:0]  r_quo_a, r_quo_b;
        logic [SIDE_W-1:0] r_side;

        assign sh_a = {{(EXT_W-DVS_W){1'b0}}, w_dvs_a[k]} << (QUO_W-1-k);
        assign sh_b = {{(EXT_W-DVS_W){1'b0}}, w_dvs_b[k]} << (QUO_W-1-k);
        assign ge_a = {{QUO_W{1'b0}}, w_rem_a[k]} >= sh_a;
        assign ge_b = {{QUO_W{1'b0}}, w_rem_b[k]} >= sh_b;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_a <= ge_a ? w_rem_a[k] - sh_a[DVD_W-1:0] : w_rem_a[k];
                r_rem_b <= ge_b ? w_rem_b[k] - sh_b[DVD_W-1:0] : w_rem_b[k];
                r_dvs_a <= w_dvs_a[k];
                r_dvs_b <= w_dvs_b[k];
                r_quo_a <= {w_quo_a[k][QUO_W-2:0], ge_a};
                r_quo_b <= {w_quo_b[k][QUO_W-2:0], ge_b};
                r_side  <= w_side[k];
            end
        end

        assign w_vld[k+1]   = r_vld;
        assign w_rem_a[k+1] = r_rem_a;
        assign w_rem_b[k+1] = r_rem_b;
        assign w_dvs_a[k+1] = r_dvs_a;
        assign w_dvs_b[k+1] = r_dvs_b;
        assign w_quo_a[k+1] = r_quo_a;
        assign w_quo_b[k+1] = r_quo_b;
        assign w_side[k+1]  = r_side;
    end

    assign o_valid = w_vld[QUO_W];
    assign o_quo_a = w_quo_a[QUO_W];
    assign o_quo_b = w_quo_b[QUO_W];
    assign o_side  = w_side[QUO_W];

endmodule

/* sv/led_brightness_word_builder_top.sv */
// Pixel to serializer word converter with a forced brightness.
// i_pix carries one RGB pixel and its last flag per request. o_word carries
// the word green<<24 | red<<16 | blue<<8 and the copied last flag.
// i_cfg writes the brightness register; it is always ready and should only
// be written while no pixel is in flight.
// The pipeline accepts one pixel every cycle while the receiver does not
// stall. The pixel passes fourteen register stages: the input stage, one
// stage that forms the hue and saturation fractions, eight stages of the
// restoring divider pair, two stages of back conversion products, one
// reciprocal multiply stage that divides by 255 and 65025, and the output
// register.
// When the receiver stalls, the whole pipeline holds and i_pix.ready drops
// in the same cycle, so nothing is lost or repeated.
// A synchronous reset clears every valid bit and sets brightness to 255.
module led_brightness_word_builder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blbw_pix_if.sink    i_pix,
    blbw_cfg_if.sink    i_cfg,
    blbw_word_if.source o_word
);
    import blbw_pkg::*;

    logic [7:0] r_bright;
    logic       w_en;

    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= BRIGHT_RESET;
        end else if (i_cfg.valid) begin
            r_bright <= i_cfg.brightness;
        end
    end

    logic r_ovld;
    assign w_en        = !r_ovld || o_word.ready;
    assign i_pix.ready = w_en;

    logic       r0_vld, r0_last;
    logic [7:0] r0_r, r0_g, r0_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_r    <= i_pix.red_in;
            r0_g    <= i_pix.green_in;
            r0_b    <= i_pix.blue_in;
            r0_last <= i_pix.last_pixel;
        end
    end

    logic [7:0]  mx, mn, d;
    logic [10:0] d6, num;
    logic [18:0] n_hdvd, n_sdvd;
    logic [10:0] n_hdvs, n_sdvs;

    always_comb begin
        mx = r0_r;
        if (r0_g > mx) mx = r0_g;
        if (r0_b > mx) mx = r0_b;
        mn = r0_r;
        if (r0_g < mn) mn = r0_g;
        if (r0_b < mn) mn = r0_b;
        d  = mx - mn;
        d6 = ({3'b0, d} << 2) + ({3'b0, d} << 1);
        if (d == 8'd0) begin
            num = 11'd0;
        end else if (mx == r0_r) begin
            if (r0_g >= r0_b) begin
                num = {3'b0, r0_g} - {3'b0, r0_b};
            end else begin
                num = {3'b0, r0_g} + d6 - {3'b0, r0_b};
            end
        end else if (mx == r0_g) begin
            num = {3'b0, r0_b} + ({3'b0, d} << 1) - {3'b0, r0_r};
        end else begin
            num = {3'b0, r0_r} + ({3'b0, d} << 2) - {3'b0, r0_g};
        end
        n_hdvd = ({8'b0, num} << 8) - {8'b0, num};
        n_hdvs = (d == 8'd0) ? 11'd1 : d6;
        n_sdvd = ({11'b0, d} << 8) - {11'b0, d};
        n_sdvs = (mx == 8'd0) ? 11'd1 : {3'b0, mx};
    end

    logic        r1_vld, r1_last;
    logic [18:0] r1_hdvd, r1_sdvd;
    logic [10:0] r1_hdvs, r1_sdvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_hdvd <= n_hdvd;
            r1_hdvs <= n_hdvs;
            r1_sdvd <= n_sdvd;
            r1_sdvs <= n_sdvs;
            r1_last <= r0_last;
        end
    end

    logic       f_vld;
    logic [7:0] f_hue, f_sat;
    logic [0:0] f_side;

    blbw_div2 #(.DVD_W(19), .DVS_W(11), .SIDE_W(1)) u_fwd_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_dvd_a (r1_hdvd),
        .i_dvs_a (r1_hdvs),
        .i_dvd_b (r1_sdvd),
        .i_dvs_b (r1_sdvs),
        .i_side  (r1_last),
        .o_valid (f_vld),
        .o_quo_a (f_hue),
        .o_quo_b (f_sat),
        .o_side  (f_side)
    );

    logic [10:0] h6;
    logic [8:0]  ph;
    logic [7:0]  ph_dev, f, sinv;
    logic [15:0] sf;
    logic [16:0] t17;
    t_sector     n_sect;

    always_comb begin
        h6 = ({3'b0, f_hue} << 2) + ({3'b0, f_hue} << 1);
        if (h6 >= 11'd1530) begin
            ph = 9'(h6 - 11'd1530);
        end else if (h6 >= 11'd1020) begin
            ph = 9'(h6 - 11'd1020);
        end else if (h6 >= 11'd510) begin
            ph = 9'(h6 - 11'd510);
        end else begin
            ph = h6[8:0];
        end
        ph_dev = (ph >= 9'd255) ? 8'(ph - 9'd255) : 8'(9'd255 - ph);
        f      = 8'd255 - ph_dev;
        if (h6 >= 11'd1275) begin
            n_sect = SECT_5;
        end else if (h6 >= 11'd1020) begin
            n_sect = SECT_4;
        end else if (h6 >= 11'd765) begin
            n_sect = SECT_3;
        end else if (h6 >= 11'd510) begin
            n_sect = SECT_2;
        end else if (h6 >= 11'd255) begin
            n_sect = SECT_1;
        end else begin
            n_sect = SECT_0;
        end
        sinv = 8'd255 - f_sat;
        sf   = {8'b0, f_sat} * {8'b0, f};
        t17  = ({9'b0, sinv} << 8) - {9'b0, sinv} + {1'b0, sf};
    end

    logic        r2_vld, r2_last;
    logic [7:0]  r2_v;
    logic [15:0] r2_x, r2_t;
    t_sector     r2_sect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x    <= {8'b0, r_bright} * {8'b0, sinv};
            r2_t    <= t17[15:0];
            r2_v    <= r_bright;
            r2_sect <= n_sect;
            r2_last <= f_side[0];
        end
    end

    logic        r3_vld, r3_last;
    logic [7:0]  r3_v;
    logic [15:0] r3_x;
    logic [23:0] r3_m;
    t_sector     r3_sect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_m    <= {16'b0, r2_v} * {8'b0, r2_t};
            r3_x    <= r2_x;
            r3_v    <= r2_v;
            r3_sect <= r2_sect;
            r3_last <= r2_last;
        end
    end

    logic [31:0] n_lprod;
    logic [47:0] n_mprod;

    always_comb begin
        n_lprod = {16'b0, r3_x} * {15'b0, RECIP_LOW};
        n_mprod = {24'b0, r3_m} * {23'b0, RECIP_MID};
    end

    logic        r4_vld, r4_last;
    logic [7:0]  r4_v, r4_low, r4_mid;
    t_sector     r4_sect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_low  <= n_lprod[31:24];
            r4_mid  <= n_mprod[47:40];
            r4_v    <= r3_v;
            r4_sect <= r3_sect;
            r4_last <= r3_last;
        end
    end

    logic        b_vld;
    logic [7:0]  b_low, b_mid;

    assign b_vld = r4_vld;
    assign b_low = r4_low;
    assign b_mid = r4_mid;

    logic [7:0] ro, go, bo, bv;
    t_sector    b_sect;

    always_comb begin
        bv     = r4_v;
        b_sect = r4_sect;
        case (b_sect)
            SECT_0: begin ro = bv;    go = b_mid; bo = b_low; end
            SECT_1: begin ro = b_mid; go = bv;    bo = b_low; end
            SECT_2: begin ro = b_low; go = bv;    bo = b_mid; end
            SECT_3: begin ro = b_low; go = b_mid; bo = bv;    end
            SECT_4: begin ro = b_mid; go = b_low; bo = bv;    end
            default: begin ro = bv;   go = b_low; bo = b_mid; end
        endcase
    end

    logic [31:0] r_word;
    logic        r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_word <= {go, ro, bo, 8'h00};
            r_last <= r4_last;
        end
    end

    assign o_word.valid     = r_ovld;
    assign o_word.led_word  = r_word;
    assign o_word.last_word = r_last;

`ifndef SYNTHESIS
    a_bright_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_bright == BRIGHT_RESET)
        else $error("brightness not restored by reset");
    a_low_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> o_word.led_word[7:0] == 8'h00)
        else $error("low byte of word not zero");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !o_word.ready |=> r_ovld && $stable(r_word) && $stable(r3_vld))
        else $error("pipeline moved during stall");
    a_chroma_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_vld && w_en |=> r_word[31:24] == $past(bv) || r_word[23:16] == $past(bv)
        || r_word[15:8] == $past(bv))
        else $error("no channel carries the brightness");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import blbw_pkg::*;

    localparam int PIPE_LAT = 13;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_word;

    typedef struct {
        t_pixel pix;
        logic   known;
        t_word  want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    blbw_pix_if  pix_bus();
    blbw_cfg_if  cfg_bus();
    blbw_word_if word_bus();

    led_brightness_word_builder_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_bus.sink),
        .i_cfg  (cfg_bus.sink),
        .o_word (word_bus.source)
    );

    always #1 i_clk = ~i_clk;

    logic [7:0] bright_model;
    t_word      pending_words[$];
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    bit         no_idle = 0;
    int         stall_left = 0;

    function automatic t_word convert_pixel(t_pixel p, logic [7:0] v8);
        int unsigned r, g, b, mx, mn, d, num, h, s, v, sector, ph, dev, f;
        int unsigned full, low, mid, ro, go, bo;
        t_word w;
        r = p.red; g = p.green; b = p.blue; v = v8;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d == 0) h = 0;
        else begin
            if (mx == r) num = (g >= b) ? (g - b) : (g + 6 * d - b);
            else if (mx == g) num = b + 2 * d - r;
            else num = r + 4 * d - g;
            h = (255 * num) / (6 * d);
        end
        s = (mx == 0) ? 0 : (255 * d) / mx;
        sector = (6 * h) / 255;
        ph = (6 * h) % 510;
        dev = (ph >= 255) ? ph - 255 : 255 - ph;
        f = 255 - dev;
        full = v;
        low = (v * (255 - s)) / 255;
        mid = (v * 65025 - 255 * s * v + s * v * f) / 65025;
        case (sector)
            SECT_0: begin ro = full; go = mid; bo = low; end
            SECT_1: begin ro = mid; go = full; bo = low; end
            SECT_2: begin ro = low; go = full; bo = mid; end
            SECT_3: begin ro = low; go = mid; bo = full; end
            SECT_4: begin ro = mid; go = low; bo = full; end
            default: begin ro = full; go = low; bo = mid; end
        endcase
        w.word = {go[7:0], ro[7:0], bo[7:0], 8'h00};
        w.last = p.last;
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Receiver side: random stalls and word checking.
    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            word_bus.ready <= 1'b0;
        end else begin
            if (word_bus.valid && word_bus.ready) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("unexpected word", word_bus.led_word, 32'h0);
                end else begin
                    want = pending_words.pop_front();
                    if (word_bus.led_word !== want.word)
                        report_mismatch("led_word", word_bus.led_word, want.word);
                    if (word_bus.last_word !== want.last)
                        report_mismatch("last_word", {31'b0, word_bus.last_word},
                                        {31'b0, want.last});
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                word_bus.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 4);
                word_bus.ready <= 1'b0;
            end else begin
                word_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_bus.valid && pix_bus.ready) || (word_bus.valid && word_bus.ready)
                || cfg_bus.valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_pixel(t_pixel p, bit allow_gap);
        int gap;
        if (allow_gap && !no_idle && $urandom_range(0, 5) == 0) begin
            pix_bus.valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.red_in <= p.red;
        pix_bus.green_in <= p.green;
        pix_bus.blue_in <= p.blue;
        pix_bus.last_pixel <= p.last;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
        pending_words.push_back(convert_pixel(p, bright_model));
    endtask

    task automatic drain_words();
        pix_bus.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_brightness(logic [7:0] value);
        drain_words();
        cfg_bus.valid <= 1'b1;
        cfg_bus.brightness <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        bright_model = value;
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p.red = $urandom_range(0, 255);
        p.green = $urandom_range(0, 255);
        p.blue = $urandom_range(0, 255);
        p.last = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    initial begin
        t_row rows[$];
        t_row row;
        t_pixel p;
        logic [7:0] levels[5];
        int n;
        pix_bus.valid = 1'b0;
        pix_bus.red_in = '0;
        pix_bus.green_in = '0;
        pix_bus.blue_in = '0;
        pix_bus.last_pixel = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.brightness = '0;
        bright_model = BRIGHT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels at reset brightness; known answers where obvious.
        rows.push_back('{'{8'd0, 8'd0, 8'd0, 1'b0}, 1'b1, '{32'hFFFFFF00, 1'b0}});
        rows.push_back('{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{32'hFFFFFF00, 1'b1}});
        rows.push_back('{'{8'd255, 8'd0, 8'd0, 1'b0}, 1'b1, '{32'h00FF0000, 1'b0}});
        rows.push_back('{'{8'd0, 8'd255, 8'd0, 1'b0}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd0, 8'd0, 8'd255, 1'b0}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd255, 8'd0, 8'd1, 1'b0}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd255, 8'd1, 8'd0, 1'b0}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd200, 8'd10, 8'd90, 1'b1}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd200, 8'd200, 8'd5, 1'b0}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd5, 8'd200, 8'd200, 1'b0}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd30, 8'd60, 8'd250, 1'b0}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd1, 8'd0, 8'd0, 1'b0}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd128, 8'd128, 8'd127, 1'b0}, 1'b0, '{32'h0, 1'b0}});
        rows.push_back('{'{8'd170, 8'd85, 8'd255, 1'b1}, 1'b0, '{32'h0, 1'b0}});
        foreach (rows[i]) begin
            row = rows[i];
            if (row.known) begin
                send_pixel(row.pix, 1'b1);
                void'(pending_words.pop_back());
                pending_words.push_back(row.want);
            end else begin
                send_pixel(row.pix, 1'b1);
            end
        end

        // The sender waits for every word before changing brightness.
        levels = '{8'd0, 8'd1, 8'd128, 8'd77, 8'd255};
        foreach (levels[k]) begin
            write_brightness(levels[k]);
            foreach (rows[i]) send_pixel(rows[i].pix, 1'b1);
            n = 185;
            if (k == 4) no_idle = 1;
            for (int j = 0; j < n; j++) begin
                p = rand_pixel();
                if (j % 4 == 0) p.green = p.red;
                if (j % 7 == 0) p.blue = p.red;
                send_pixel(p, 1'b1);
            end
        end
        drain_words();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* sim.f */
sv/blbw_pkg.sv
sv/blbw_if.sv
sv/blbw_div2.sv
sv/led_brightness_word_builder_top.sv
sim/testbench.sv
